/* hdl/ideq_pkg.sv */
// ----------------------------------------------------------------------------
// ideq_pkg
// Shared constants, request and status codes and ring helpers for the
// indexed deque engine.
// ----------------------------------------------------------------------------
package ideq_pkg;

	localparam int DEPTH       = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int RUN_LIMIT   = 32;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int RUN_W = $clog2(RUN_LIMIT + 1);

	localparam int REQ_W     = 4;
	localparam int IDX_W     = 16;
	localparam int IN_VAL_W  = 32;
	localparam int STATUS_W  = 3;
	localparam int OUT_VAL_W = 32;
	localparam int LEN_W     = 6;
	localparam int ARITH_W   = IDX_W + 2;

	localparam int IN_RAW_W    = REQ_W + 2 * IDX_W + IN_VAL_W;
	localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W   = STATUS_W + OUT_VAL_W + 1 + LEN_W;
	localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	typedef logic [REQ_W-1:0]       req_t;
	typedef logic [STATUS_W-1:0]    status_t;
	typedef logic [PTR_W-1:0]       ptr_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [VALUE_WIDTH-1:0] word_t;

	localparam req_t REQ_PUSH_L    = req_t'(0);
	localparam req_t REQ_PUSH_R    = req_t'(1);
	localparam req_t REQ_PUSH_L_EX = req_t'(2);
	localparam req_t REQ_PUSH_R_EX = req_t'(3);
	localparam req_t REQ_POP_L     = req_t'(4);
	localparam req_t REQ_POP_R     = req_t'(5);
	localparam req_t REQ_READ      = req_t'(6);
	localparam req_t REQ_WRITE     = req_t'(7);
	localparam req_t REQ_RANGE     = req_t'(8);
	localparam req_t REQ_TRIM      = req_t'(9);
	localparam req_t REQ_CLEAR     = req_t'(10);

	localparam status_t ST_OK      = status_t'(0);
	localparam status_t ST_NO_LIST = status_t'(1);
	localparam status_t ST_RANGE   = status_t'(2);
	localparam status_t ST_EMPTY   = status_t'(3);
	localparam status_t ST_FULL    = status_t'(4);

	// (head + pos) mod DEPTH, both operands below DEPTH
	function automatic ptr_t slot_of(ptr_t head, ptr_t pos);
		logic [PTR_W:0] s;
		s = {1'b0, head} + {1'b0, pos};
		if (s >= (PTR_W + 1)'(DEPTH))
			s = s - (PTR_W + 1)'(DEPTH);
		return s[PTR_W-1:0];
	endfunction

	function automatic ptr_t ptr_inc(ptr_t p);
		return (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic ptr_t ptr_dec(ptr_t p);
		return (p == '0) ? ptr_t'(DEPTH - 1) : p - ptr_t'(1);
	endfunction

endpackage

/* hdl/indexed_deque_engine_top.sv */
// ----------------------------------------------------------------------------
// indexed_deque_engine_top
// Ring-buffer list of words with push/pop at both ends, indexed read and
// write, range read, trim and clear.
// ----------------------------------------------------------------------------
// Push, write, trim, clear, an empty range read and every refused request
// complete in the cycle they are accepted and their result is registered for
// the next cycle. Pop and indexed read go through the element memory's
// registered read port, so the result passes the read-data register and then
// the output register. A range read issues one memory read per cycle and emits
// one element per cycle while the output is taken, up to RUN_LIMIT elements, the
// final one marked by m_tlast. A new request is taken once the block is idle, no
// read result is pending and the output register is free or being emptied. The
// element store needs no clearing after reset.
module indexed_deque_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// req_type[3:0], first_index[19:4], second_index[35:20],
	// element_value[67:36], zero pad
	input  logic [ideq_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[2:0], out_value[34:3], value_valid[35], list_length[41:36],
	// zero pad
	output logic [ideq_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                              m_tlast
);
	import ideq_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_SWEEP = 1'b1;

	logic state_q, state_n;

	word_t element_store_q [DEPTH];
	word_t rd_data_s1;

	ptr_t  head_q, head_n;
	cnt_t  cnt_q, cnt_n;
	logic  exists_q, exists_n;
	ptr_t  cursor_q, cursor_n;
	logic [RUN_W-1:0] remain_q, remain_n;

	logic  pend_s1, last_s1;
	logic [LEN_W-1:0] len_s1;

	logic  out_valid_q, out_last_q, out_vvalid_q;
	status_t out_status_q;
	logic [OUT_VAL_W-1:0] out_value_q;
	logic [LEN_W-1:0] out_len_q;

	logic  out_free, take;
	req_t  req;
	logic signed [IDX_W-1:0] a_in, b_in;
	word_t v_in;

	logic signed [ARITH_W-1:0] m_s, a_x, b_x, idx, ca, cb, span;
	logic  idx_ok, empty;
	logic [RUN_W-1:0] run_len;

	logic  mem_we, mem_re;
	ptr_t  mem_waddr, mem_raddr;
	word_t mem_wdata;

	logic  issue, issue_last;
	logic [LEN_W-1:0] issue_len;
	logic  ld;
	status_t ld_status;
	logic [LEN_W-1:0] ld_len;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && !pend_s1 && out_free;
	assign take     = s_tvalid && s_tready;

	assign req  = s_tdata[REQ_W-1:0];
	assign a_in = signed'(s_tdata[REQ_W +: IDX_W]);
	assign b_in = signed'(s_tdata[REQ_W + IDX_W +: IDX_W]);
	assign v_in = VALUE_WIDTH'(s_tdata[REQ_W + 2 * IDX_W +: IN_VAL_W]);

	// index and bound arithmetic
	always_comb begin
		m_s   = signed'(ARITH_W'(cnt_q));
		a_x   = ARITH_W'(a_in);
		b_x   = ARITH_W'(b_in);
		empty = (cnt_q == '0);

		idx    = (a_x < 0) ? a_x + m_s : a_x;
		idx_ok = (idx >= 0) && (idx < m_s);

		if (a_x < 0) begin
			ca = a_x + m_s;
			if (ca < 0)
				ca = '0;
		end else begin
			ca = a_x;
		end
		if (b_x < 0) begin
			cb = b_x + m_s;
			if (cb < 0)
				cb = '0;
		end else begin
			cb = b_x;
		end
		if (ca > m_s - 1)
			ca = m_s - 1;
		if (cb >= m_s - 1)
			cb = m_s - 1;

		span    = cb - ca + ARITH_W'(1);
		run_len = (span > ARITH_W'(RUN_LIMIT)) ? RUN_W'(RUN_LIMIT) : RUN_W'(span);
	end

	always_comb begin
		state_n    = state_q;
		head_n     = head_q;
		cnt_n      = cnt_q;
		exists_n   = exists_q;
		cursor_n   = cursor_q;
		remain_n   = remain_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = '0;
		mem_raddr  = '0;
		mem_wdata  = v_in;
		issue      = 1'b0;
		issue_last = 1'b1;
		issue_len  = LEN_W'(cnt_q);
		ld         = 1'b0;
		ld_status  = ST_OK;
		ld_len     = LEN_W'(cnt_q);

		if (take) begin
			unique case (req) inside
				REQ_CLEAR: begin
					exists_n = 1'b0;
					cnt_n    = '0;
					head_n   = '0;
					ld       = 1'b1;
					ld_len   = '0;
				end
				REQ_PUSH_L, REQ_PUSH_R, REQ_PUSH_L_EX, REQ_PUSH_R_EX: begin
					ld = 1'b1;
					if (!exists_q && (req == REQ_PUSH_L_EX || req == REQ_PUSH_R_EX)) begin
						ld_status = ST_NO_LIST;
						ld_len    = '0;
					end else if (cnt_q >= CNT_W'(DEPTH)) begin
						ld_status = ST_FULL;
					end else begin
						exists_n = 1'b1;
						mem_we   = 1'b1;
						if (!req[0]) begin
							head_n    = ptr_dec(head_q);
							mem_waddr = ptr_dec(head_q);
						end else begin
							mem_waddr = slot_of(head_q, ptr_t'(cnt_q));
						end
						cnt_n  = cnt_q + CNT_W'(1);
						ld_len = LEN_W'(cnt_q + CNT_W'(1));
					end
				end
				REQ_POP_L, REQ_POP_R, REQ_READ, REQ_WRITE, REQ_RANGE, REQ_TRIM: begin
					if (!exists_q) begin
						ld        = 1'b1;
						ld_status = ST_NO_LIST;
						ld_len    = '0;
					end else begin
						unique case (req) inside
							REQ_POP_L, REQ_POP_R: begin
								if (empty) begin
									ld        = 1'b1;
									ld_status = ST_EMPTY;
								end else begin
									mem_re    = 1'b1;
									issue     = 1'b1;
									cnt_n     = cnt_q - CNT_W'(1);
									issue_len = LEN_W'(cnt_q - CNT_W'(1));
									if (req == REQ_POP_L) begin
										mem_raddr = head_q;
										head_n    = ptr_inc(head_q);
									end else begin
										mem_raddr = slot_of(head_q, ptr_t'(cnt_q - CNT_W'(1)));
									end
								end
							end
							REQ_READ, REQ_WRITE: begin
								if (!idx_ok) begin
									ld        = 1'b1;
									ld_status = ST_RANGE;
								end else if (req == REQ_READ) begin
									mem_re    = 1'b1;
									issue     = 1'b1;
									mem_raddr = slot_of(head_q, idx[PTR_W-1:0]);
								end else begin
									mem_we    = 1'b1;
									mem_waddr = slot_of(head_q, idx[PTR_W-1:0]);
									ld        = 1'b1;
								end
							end
							REQ_RANGE: begin
								if (empty) begin
									ld        = 1'b1;
									ld_status = ST_RANGE;
								end else if (ca > cb) begin
									ld = 1'b1;
								end else begin
									mem_re     = 1'b1;
									issue      = 1'b1;
									mem_raddr  = slot_of(head_q, ca[PTR_W-1:0]);
									cursor_n   = ptr_inc(slot_of(head_q, ca[PTR_W-1:0]));
									remain_n   = run_len - RUN_W'(1);
									issue_last = (run_len == RUN_W'(1));
									if (run_len != RUN_W'(1))
										state_n = ST_SWEEP;
								end
							end
							default: begin
								ld = 1'b1;
								if (empty) begin
									ld_status = ST_RANGE;
								end else if (ca > cb) begin
									cnt_n  = '0;
									ld_len = '0;
								end else begin
									head_n = slot_of(head_q, ca[PTR_W-1:0]);
									cnt_n  = CNT_W'(span);
									ld_len = LEN_W'(span);
								end
							end
						endcase
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_SWEEP && (!pend_s1 || out_free)) begin
			mem_re     = 1'b1;
			issue      = 1'b1;
			mem_raddr  = cursor_q;
			cursor_n   = ptr_inc(cursor_q);
			remain_n   = remain_q - RUN_W'(1);
			issue_last = (remain_q == RUN_W'(1));
			if (remain_q == RUN_W'(1))
				state_n = ST_IDLE;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			element_store_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_s1 <= element_store_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			cnt_q       <= '0;
			exists_q    <= 1'b0;
			cursor_q    <= '0;
			remain_q    <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			head_q   <= head_n;
			cnt_q    <= cnt_n;
			exists_q <= exists_n;
			cursor_q <= cursor_n;
			remain_q <= remain_n;

			if (issue)
				pend_s1 <= 1'b1;
			else if (pend_s1 && out_free)
				pend_s1 <= 1'b0;

			if ((pend_s1 && out_free) || ld)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= issue_last;
			len_s1  <= issue_len;
		end
		if (pend_s1 && out_free) begin
			out_status_q <= ST_OK;
			out_value_q  <= OUT_VAL_W'(rd_data_s1);
			out_vvalid_q <= 1'b1;
			out_len_q    <= len_s1;
			out_last_q   <= last_s1;
		end else if (ld) begin
			out_status_q <= ld_status;
			out_value_q  <= '0;
			out_vvalid_q <= 1'b0;
			out_len_q    <= ld_len;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(OUT_TDATA_W - OUT_RAW_W)'(0), out_len_q, out_vvalid_q,
		out_value_q, out_status_q};

endmodule

/* sim/ideq_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ideq_result_checker
// Follows the deque state from every accepted request transaction, forms
// the replies each one must produce and compares every reply transaction,
// field by field, with the oldest one still due.
// ----------------------------------------------------------------------------
module ideq_result_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [ideq_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [ideq_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             m_tlast,
	output int                               mismatches,
	output int                               replies_due,
	output int                               length_hint
);
	import ideq_pkg::*;

	localparam int A_LSB = REQ_W;
	localparam int B_LSB = REQ_W + IDX_W;
	localparam int V_LSB = REQ_W + 2 * IDX_W;

	// lowest bits first on the wire, so the struct runs from the top down
	typedef struct packed {
		logic                 last;
		logic [LEN_W-1:0]     length;
		logic                 value_valid;
		logic [OUT_VAL_W-1:0] value;
		status_t              status;
	} reply_t;

	reply_t reply_q[$];
	word_t  ring [DEPTH];
	ptr_t   head = '0;
	int     count = 0;
	logic   exists = 1'b0;
	int     mismatch_count = 0;
	int     due_count = 0;
	int     len_seen = 0;

	assign mismatches  = mismatch_count;
	assign replies_due = due_count;
	assign length_hint = len_seen;

	function automatic ptr_t ring_pos(int pos);
		return ptr_t'((int'(head) + pos) % DEPTH);
	endfunction

	function automatic int floor_bound(int x, int m);
		if (x < 0)
			x = x + m;
		return (x < 0) ? 0 : x;
	endfunction

	function automatic void add_reply(status_t st, word_t val, logic vv, logic last);
		reply_t r;
		r.status      = st;
		r.value       = vv ? val : '0;
		r.value_valid = vv;
		r.length      = exists ? LEN_W'(count) : '0;
		r.last        = last;
		reply_q = {reply_q, r};
	endfunction

	task automatic apply_request(req_t req, int a, int b, word_t v);
		int    m;
		int    lo;
		int    hi;
		int    idx;
		int    n;
		word_t val;
		m = count;
		if (req > REQ_CLEAR)
			return;
		if (req == REQ_CLEAR) begin
			exists = 1'b0;
			count  = 0;
			head   = '0;
			add_reply(ST_OK, '0, 1'b0, 1'b1);
			return;
		end
		if (!exists) begin
			if (req == REQ_PUSH_L || req == REQ_PUSH_R) begin
				exists = 1'b1;
				count  = 0;
				head   = '0;
			end else begin
				add_reply(ST_NO_LIST, '0, 1'b0, 1'b1);
				return;
			end
		end
		case (req)
		REQ_PUSH_L, REQ_PUSH_R, REQ_PUSH_L_EX, REQ_PUSH_R_EX: begin
			if (count >= DEPTH) begin
				add_reply(ST_FULL, '0, 1'b0, 1'b1);
			end else begin
				if (req == REQ_PUSH_L || req == REQ_PUSH_L_EX) begin
					head = ring_pos(DEPTH - 1);
					ring[head] = v;
				end else begin
					ring[ring_pos(count)] = v;
				end
				count++;
				add_reply(ST_OK, '0, 1'b0, 1'b1);
			end
		end
		REQ_POP_L, REQ_POP_R: begin
			if (count == 0) begin
				add_reply(ST_EMPTY, '0, 1'b0, 1'b1);
			end else if (req == REQ_POP_L) begin
				val  = ring[head];
				head = ring_pos(1);
				count--;
				add_reply(ST_OK, val, 1'b1, 1'b1);
			end else begin
				val = ring[ring_pos(count - 1)];
				count--;
				add_reply(ST_OK, val, 1'b1, 1'b1);
			end
		end
		REQ_READ, REQ_WRITE: begin
			idx = (a < 0) ? a + m : a;
			if (idx < 0 || idx >= m) begin
				add_reply(ST_RANGE, '0, 1'b0, 1'b1);
			end else if (req == REQ_WRITE) begin
				ring[ring_pos(idx)] = v;
				add_reply(ST_OK, '0, 1'b0, 1'b1);
			end else begin
				add_reply(ST_OK, ring[ring_pos(idx)], 1'b1, 1'b1);
			end
		end
		default: begin
			lo = floor_bound(a, m);
			hi = floor_bound(b, m);
			if (lo > m - 1)
				lo = m - 1;
			if (hi > m - 1)
				hi = m - 1;
			if (lo < 0 || hi < 0) begin
				add_reply(ST_RANGE, '0, 1'b0, 1'b1);
			end else if (req == REQ_RANGE) begin
				if (lo > hi) begin
					add_reply(ST_OK, '0, 1'b0, 1'b1);
				end else begin
					n = hi - lo + 1;
					if (n > RUN_LIMIT)
						n = RUN_LIMIT;
					for (int k = 0; k < n; k++)
						add_reply(ST_OK, ring[ring_pos(lo + k)], 1'b1, k == n - 1);
				end
			end else begin
				if (lo > hi) begin
					count = 0;
				end else begin
					head  = ring_pos(lo);
					count = hi - lo + 1;
				end
				add_reply(ST_OK, '0, 1'b0, 1'b1);
			end
		end
		endcase
	endtask

	always @(posedge clk) begin : watch
		reply_t got;
		reply_t want;
		logic   bad;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = reply_t'({m_tlast, m_tdata[OUT_RAW_W-1:0]});
				if (reply_q.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected reply st=%0d val=%h vv=%b len=%0d last=%b",
							$time, got.status, got.value, got.value_valid, got.length,
							got.last);
					mismatch_count++;
				end else begin
					want = reply_q.pop_front();
					bad  = (got.status !== want.status) || (got.value !== want.value) ||
						(got.value_valid !== want.value_valid) ||
						(got.length !== want.length) || (got.last !== want.last);
					if (bad) begin
						if (mismatch_count < 10) begin
							$write("%0t: reply mismatch, want st=%0d val=%h vv=%b len=%0d",
								$time, want.status, want.value, want.value_valid,
								want.length);
							$display(" last=%b, got st=%0d val=%h vv=%b len=%0d last=%b",
								want.last, got.status, got.value, got.value_valid,
								got.length, got.last);
						end
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				apply_request(s_tdata[REQ_W-1:0], $signed(s_tdata[B_LSB-1:A_LSB]),
					$signed(s_tdata[V_LSB-1:B_LSB]), s_tdata[V_LSB+IN_VAL_W-1:V_LSB]);
		end
		due_count <= reply_q.size();
		len_seen  <= exists ? count : 0;
	end

endmodule

/* sim/indexed_deque_engine_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_engine_top_tb
// Drives request transactions into the deque engine: a short directed run
// over every request and corner, then random traffic with fill bursts,
// under varying idle rates on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module indexed_deque_engine_top_tb;
	import ideq_pkg::*;

	localparam int ITEM_TARGET     = 270;
	localparam int HOLD_OFF_CYCLES = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;

	int   mismatches;
	int   replies_due;
	int   length_hint;
	int   tx_idle_pct   = 0;
	int   rx_idle_pct   = 0;
	int   sent          = 0;
	logic hold_off_go   = 1'b0;
	logic hold_off_done = 1'b0;

	indexed_deque_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ideq_result_checker reply_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.replies_due (replies_due),
		.length_hint (length_hint)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("indexed_deque_engine_top verification failed");
		$finish;
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_go && !hold_off_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic send_request(req_t req, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
		word_t v);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({v, b, a, req});
		do
			@(posedge clk);
		while (!s_tready);
		if (req <= REQ_CLEAR)
			sent++;
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_due != 0)
			@(posedge clk);
	endtask

	function automatic logic [IDX_W-1:0] pick_index(int len);
		case ($urandom_range(9))
		0:       return IDX_W'($urandom);
		1:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		default: return IDX_W'(int'($urandom_range(2 * len + 4)) - (len + 2));
		endcase
	endfunction

	function automatic word_t pick_value();
		case ($urandom_range(7))
		0:       return '0;
		1:       return '1;
		default: return $urandom;
		endcase
	endfunction

	task automatic random_request();
		int   pick;
		req_t req;
		pick = $urandom_range(99);
		if (pick < 32)
			req = req_t'($urandom_range(REQ_PUSH_R_EX, REQ_PUSH_L));
		else if (pick < 46)
			req = $urandom_range(1) ? REQ_POP_L : REQ_POP_R;
		else if (pick < 60)
			req = REQ_READ;
		else if (pick < 72)
			req = REQ_WRITE;
		else if (pick < 86)
			req = REQ_RANGE;
		else if (pick < 91)
			req = REQ_TRIM;
		else if (pick < 95)
			req = REQ_CLEAR;
		else
			req = req_t'(REQ_CLEAR + $urandom_range(5, 1));
		send_request(req, pick_index(length_hint), pick_index(length_hint), pick_value());
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 16;
		rx_idle_pct = 74;

		send_request(REQ_POP_L,     16'h0000, 16'h0000, '0);
		send_request(REQ_READ,      16'h0000, 16'h0000, '0);
		send_request(REQ_PUSH_L_EX, 16'h0000, 16'h0000, '1);
		send_request(REQ_TRIM,      16'h0000, 16'hFFFF, '0);
		send_request(REQ_CLEAR,     16'h0000, 16'h0000, '0);
		send_request(REQ_PUSH_R,    16'h0000, 16'h0000, '1);
		send_request(REQ_POP_R,     16'h0000, 16'h0000, '0);
		send_request(REQ_POP_L,     16'h0000, 16'h0000, '0);
		send_request(REQ_RANGE,     16'h0000, 16'hFFFF, '0);
		send_request(REQ_TRIM,      16'h0000, 16'h0000, '0);
		send_request(REQ_WRITE,     16'h0000, 16'h0000, 32'h0F0F_0F0F);
		send_request(REQ_PUSH_R_EX, 16'h0000, 16'h0000, '0);
		send_request(REQ_PUSH_L_EX, 16'h0000, 16'h0000, 32'h8000_0001);
		send_request(REQ_PUSH_L,    16'h0000, 16'h0000, 32'h7FFF_FFFE);
		send_request(REQ_PUSH_R,    16'h0000, 16'h0000, 32'hA5A5_5A5A);
		send_request(REQ_READ,      16'hFFFF, 16'h0000, '0);
		send_request(REQ_READ,      16'h8000, 16'h0000, '0);
		send_request(REQ_WRITE,     16'h7FFF, 16'h0000, '1);
		send_request(REQ_WRITE,     16'hFFFC, 16'h0000, 32'h1234_5678);
		send_request(REQ_RANGE,     16'h8000, 16'h7FFF, '0);
		send_request(REQ_RANGE,     16'h0003, 16'h0001, '0);
		send_request(REQ_TRIM,      16'h0001, 16'hFFFE, '0);
		send_request(REQ_TRIM,      16'h0001, 16'h0000, '0);
		send_request(REQ_POP_R,     16'h0000, 16'h0000, '0);
		send_request(REQ_CLEAR,     16'h0000, 16'h0000, '0);
		drain_replies();

		sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 74 : 0;
			rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 16 : 0;
			if (phase == 2)
				hold_off_go = 1'b1;
			while (sent < ITEM_TARGET * (phase + 1) / 3) begin
				if ($urandom_range(15) == 0) begin
					// fill past capacity, then read the whole ring back
					repeat (DEPTH + 3)
						send_request(req_t'($urandom_range(REQ_PUSH_R_EX, REQ_PUSH_L)),
							pick_index(8), pick_index(8), pick_value());
					send_request(REQ_RANGE, IDX_W'(0), IDX_W'(-1), '0);
				end else begin
					random_request();
				end
			end
			drain_replies();
		end

		repeat (16) @(posedge clk);
		if (mismatches == 0 && replies_due == 0)
			$display("indexed_deque_engine_top verification clean");
		else
			$display("indexed_deque_engine_top verification failed");
		$finish;
	end

endmodule

/* filelist.f */
hdl/ideq_pkg.sv
hdl/indexed_deque_engine_top.sv
sim/ideq_result_checker.sv
sim/indexed_deque_engine_top_tb.sv
